@@ rtl/lbpd_pkg.sv @@
// ---------------------------------------------------------------------------
// lbpd_pkg
// Shared widths, limits, neighbour tables and types of the label boundary
// pair detector.
// ---------------------------------------------------------------------------
package lbpd_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int MAX_DEPTH  = 1024;
    localparam int HIST_SIZE  = MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1;
    localparam int PTR_W      = $clog2(HIST_SIZE + 1);

    localparam int LBL_W = 8;
    localparam int X_W   = 9;
    localparam int Y_W   = 9;
    localparam int Z_W   = 10;
    localparam int W_W   = 10;
    localparam int H_W   = 10;
    localparam int D_W   = 11;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int NB     = 13;
    localparam int NGROUP = 4;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_DEPTH  = 2'd2
    } lbpd_cfg_t;

    // neighbour k in z, y, x order: which step along each axis it takes
    localparam logic [NB-1:0] NB_XM = 13'h1249;
    localparam logic [NB-1:0] NB_XP = 13'h0924;
    localparam logic [NB-1:0] NB_YM = 13'h0E07;
    localparam logic [NB-1:0] NB_YP = 13'h01C0;
    localparam logic [NB-1:0] NB_ZM = 13'h01FF;

    typedef struct packed {
        logic [LBL_W-1:0]          label;
        logic [X_W-1:0]            x;
        logic [Y_W-1:0]            y;
        logic [Z_W-1:0]            z;
        logic [NB-1:0][LBL_W-1:0]  nlab;
        logic [NB-1:0]             mask;
    } lbpd_entry_t;

    typedef struct packed {
        logic [LBL_W-1:0] low_label;
        logic [LBL_W-1:0] high_label;
        logic [X_W-1:0]   low_x;
        logic [Y_W-1:0]   low_y;
        logic [Z_W-1:0]   low_z;
        logic [X_W-1:0]   high_x;
        logic [Y_W-1:0]   high_y;
        logic [Z_W-1:0]   high_z;
        logic             last_of_run;
    } lbpd_rec_t;

endpackage

@@ rtl/label_boundary_pair_detector_3d.sv @@
// ---------------------------------------------------------------------------
// label_boundary_pair_detector_3d
// Finds differing labels among the 13 earlier 26-neighbours of each voxel
// of a raster-ordered 3D label volume and reports each pair once.
// a voxel's first record passes the s1 registers, the queue and the result register
// throughput: one voxel per cycle while full is low; records leave at one per
// cycle while pop is high, so a voxel with n differing neighbours gives n records
// reset: dimensions 512 x 512 x 1024, cursor at the origin, history
// undefined; full is high after reset and after any register
// write while the plane offsets are recomputed
// ---------------------------------------------------------------------------
module label_boundary_pair_detector_3d
    import lbpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  push,
    output logic                  full,
    input  logic [LBL_W-1:0]      voxel_label,
    output logic                  empty,
    input  logic                  pop,
    output logic [LBL_W-1:0]      low_label,
    output logic [LBL_W-1:0]      high_label,
    output logic [X_W-1:0]        low_x,
    output logic [Y_W-1:0]        low_y,
    output logic [Z_W-1:0]        low_z,
    output logic [X_W-1:0]        high_x,
    output logic [Y_W-1:0]        high_y,
    output logic [Z_W-1:0]        high_z,
    output logic                  last_of_run
);

    logic              q_push;
    lbpd_entry_t       q_wdata;
    logic              q_pop;
    lbpd_entry_t       q_head;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;
    lbpd_rec_t         rec;

    lbpd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .voxel_label (voxel_label),
        .full        (full),
        .q_count     (q_count),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    lbpd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_count (q_count)
    );

    lbpd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .rec     (rec)
    );

    assign low_label   = rec.low_label;
    assign high_label  = rec.high_label;
    assign low_x       = rec.low_x;
    assign low_y       = rec.low_y;
    assign low_z       = rec.low_z;
    assign high_x      = rec.high_x;
    assign high_y      = rec.high_y;
    assign high_z      = rec.high_z;
    assign last_of_run = rec.last_of_run;

endmodule

@@ rtl/lbpd_front.sv @@
// ---------------------------------------------------------------------------
// lbpd_front
// Accepts voxels, keeps the label history and the volume cursor, gathers
// the 13 earlier neighbours and queues voxels that have differing ones.
// ---------------------------------------------------------------------------
module lbpd_front
    import lbpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  push,
    input  logic [LBL_W-1:0]      voxel_label,
    output logic                  full,
    input  logic [QCNT_W-1:0]     q_count,
    output logic                  q_push,
    output lbpd_entry_t           q_data
);

    logic [W_W-1:0] w_reg;
    logic [H_W-1:0] h_reg;
    logic [D_W-1:0] d_reg;
    logic [1:0]     settle_reg;
    logic [PTR_W-1:0] wh_reg;
    logic [PTR_W-1:0] offc_reg [NGROUP];

    logic [X_W-1:0]   x_reg;
    logic [Y_W-1:0]   y_reg;
    logic [Z_W-1:0]   z_reg;
    logic [PTR_W-1:0] ptr_reg;
    logic [LBL_W-1:0] last_label_reg;

    logic             s1_valid_reg;
    logic [LBL_W-1:0] s1_label_reg;
    logic [LBL_W-1:0] s1_prev_reg;
    logic [X_W-1:0]   s1_x_reg;
    logic [Y_W-1:0]   s1_y_reg;
    logic [Z_W-1:0]   s1_z_reg;
    logic [NB-1:0]    s1_vmask_reg;

    logic [LBL_W-1:0] rd_reg   [NGROUP];
    logic [LBL_W-1:0] win0_reg [NGROUP];
    logic [LBL_W-1:0] win1_reg [NGROUP];

    logic [LBL_W-1:0] mem_a [HIST_SIZE];
    logic [LBL_W-1:0] mem_b [HIST_SIZE];

    logic                  accept;
    logic                  restart;
    logic [2*W_W-1:0]      wh_prod;
    logic [PTR_W:0]        off     [NGROUP];
    logic [PTR_W-1:0]      addr    [NGROUP];
    logic [PTR_W:0]        asum    [NGROUP];
    logic [X_W:0]          x1;
    logic [Y_W:0]          y1;
    logic [Z_W:0]          z1;
    logic [NB-1:0]         vmask;
    logic [NB-1:0][LBL_W-1:0] nlab;
    logic [NB-1:0]         diff;
    logic [QCNT_W:0]       occ;

    function automatic logic [W_W-1:0] clamp_w(input logic [W_W-1:0] v);
        logic [W_W-1:0] r;
        if (v == '0)
            r = W_W'(1);
        else if (v > W_W'(MAX_WIDTH))
            r = W_W'(MAX_WIDTH);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [H_W-1:0] clamp_h(input logic [H_W-1:0] v);
        logic [H_W-1:0] r;
        if (v == '0)
            r = H_W'(1);
        else if (v > H_W'(MAX_HEIGHT))
            r = H_W'(MAX_HEIGHT);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [D_W-1:0] clamp_d(input logic [D_W-1:0] v);
        logic [D_W-1:0] r;
        if (v == '0)
            r = D_W'(1);
        else if (v > D_W'(MAX_DEPTH))
            r = D_W'(MAX_DEPTH);
        else
            r = v;
        return r;
    endfunction

    assign occ    = {1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid_reg};
    assign full   = (settle_reg != 2'b00) || (occ >= (QCNT_W + 1)'(QDEPTH));
    assign accept = push && !full;

    assign restart = cfg_we && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT)
                                || (cfg_index == CFG_DEPTH));

    // configuration and derived ring offsets
    assign wh_prod = w_reg * h_reg;

    always_comb
    begin
        off[0] = {1'b0, wh_reg} + (PTR_W + 1)'(w_reg);
        off[1] = {1'b0, wh_reg};
        if (h_reg == H_W'(1))
            off[2] = (PTR_W + 1)'(w_reg);
        else
            off[2] = {1'b0, wh_reg} - (PTR_W + 1)'(w_reg);
        off[3] = (PTR_W + 1)'(w_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg      <= W_W'(MAX_WIDTH);
            h_reg      <= H_W'(MAX_HEIGHT);
            d_reg      <= D_W'(MAX_DEPTH);
            settle_reg <= 2'b11;
        end
        else
        begin
            if (cfg_we)
            begin
                settle_reg <= 2'b11;
                case (cfg_index)
                    CFG_WIDTH:  w_reg <= clamp_w(cfg_wdata[W_W-1:0]);
                    CFG_HEIGHT: h_reg <= clamp_h(cfg_wdata[H_W-1:0]);
                    CFG_DEPTH:  d_reg <= clamp_d(cfg_wdata[D_W-1:0]);
                    default:    ;
                endcase
            end
            else
            begin
                settle_reg <= {1'b0, settle_reg[1]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wh_reg <= wh_prod[PTR_W-1:0];
        for (int g = 0; g < NGROUP; g++)
            offc_reg[g] <= PTR_W'((PTR_W + 1)'(HIST_SIZE + 1) - off[g]);
    end

    // read addresses: newest column of each neighbour row
    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            asum[g] = {1'b0, ptr_reg} + {1'b0, offc_reg[g]};
            if (asum[g] >= (PTR_W + 1)'(HIST_SIZE))
                addr[g] = PTR_W'(asum[g] - (PTR_W + 1)'(HIST_SIZE));
            else
                addr[g] = asum[g][PTR_W-1:0];
        end
    end

    assign x1 = {1'b0, x_reg} + (X_W + 1)'(1);
    assign y1 = {1'b0, y_reg} + (Y_W + 1)'(1);
    assign z1 = {1'b0, z_reg} + (Z_W + 1)'(1);

    assign vmask = ~(NB_XM & {NB{x_reg == '0}})
                 & ~(NB_XP & {NB{(X_W + 1)'(w_reg) <= x1}})
                 & ~(NB_YM & {NB{y_reg == '0}})
                 & ~(NB_YP & {NB{(Y_W + 1)'(h_reg) <= y1}})
                 & ~(NB_ZM & {NB{z_reg == '0}});

    // cursor and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg        <= '0;
            y_reg        <= '0;
            z_reg        <= '0;
            ptr_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (restart)
            begin
                x_reg   <= '0;
                y_reg   <= '0;
                z_reg   <= '0;
                ptr_reg <= '0;
            end
            else if (accept)
            begin
                if (ptr_reg == PTR_W'(HIST_SIZE - 1))
                    ptr_reg <= '0;
                else
                    ptr_reg <= ptr_reg + PTR_W'(1);
                if (x1 >= (X_W + 1)'(w_reg))
                begin
                    x_reg <= '0;
                    if (y1 >= (Y_W + 1)'(h_reg))
                    begin
                        y_reg <= '0;
                        if (z1 >= (Z_W + 1)'(d_reg))
                        begin
                            z_reg   <= '0;
                            ptr_reg <= '0;
                        end
                        else
                        begin
                            z_reg <= z1[Z_W-1:0];
                        end
                    end
                    else
                    begin
                        y_reg <= y1[Y_W-1:0];
                    end
                end
                else
                begin
                    x_reg <= x1[X_W-1:0];
                end
            end
        end
    end

    // history memories, written once and read twice per voxel
    // a read of the entry being written takes the incoming label
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_a[ptr_reg] <= voxel_label;
            mem_b[ptr_reg] <= voxel_label;
            rd_reg[0]      <= (addr[0] == ptr_reg) ? voxel_label : mem_a[addr[0]];
            rd_reg[1]      <= (addr[1] == ptr_reg) ? voxel_label : mem_a[addr[1]];
            rd_reg[2]      <= (addr[2] == ptr_reg) ? voxel_label : mem_b[addr[2]];
            rd_reg[3]      <= (addr[3] == ptr_reg) ? voxel_label : mem_b[addr[3]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_label_reg   <= voxel_label;
            s1_prev_reg    <= last_label_reg;
            last_label_reg <= voxel_label;
            s1_x_reg       <= x_reg;
            s1_y_reg       <= y_reg;
            s1_z_reg       <= z_reg;
            s1_vmask_reg   <= vmask;
        end
        if (s1_valid_reg)
        begin
            for (int g = 0; g < NGROUP; g++)
            begin
                win1_reg[g] <= win0_reg[g];
                win0_reg[g] <= rd_reg[g];
            end
        end
    end

    // neighbour taps and compare
    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            nlab[3*g]     = win1_reg[g];
            nlab[3*g + 1] = win0_reg[g];
            nlab[3*g + 2] = rd_reg[g];
        end
        nlab[NB-1] = s1_prev_reg;
        for (int k = 0; k < NB; k++)
            diff[k] = s1_vmask_reg[k] && (nlab[k] != s1_label_reg);
    end

    assign q_push       = s1_valid_reg && (diff != '0);
    assign q_data.label = s1_label_reg;
    assign q_data.x     = s1_x_reg;
    assign q_data.y     = s1_y_reg;
    assign q_data.z     = s1_z_reg;
    assign q_data.nlab  = nlab;
    assign q_data.mask  = diff;

endmodule

@@ rtl/lbpd_queue.sv @@
// ---------------------------------------------------------------------------
// lbpd_queue
// Short queue of classified voxels between the front and the back.
// ---------------------------------------------------------------------------
module lbpd_queue
    import lbpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_push,
    input  lbpd_entry_t       q_wdata,
    input  logic              q_pop,
    output lbpd_entry_t       q_head,
    output logic              q_empty,
    output logic [QCNT_W-1:0] q_count
);

    lbpd_entry_t       slot_reg [QDEPTH];
    logic [QPTR_W-1:0] rp_reg;
    logic [QPTR_W-1:0] wp_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign q_head  = slot_reg[rp_reg];
    assign q_empty = (cnt_reg == '0);
    assign q_count = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg  <= '0;
            wp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (q_push)
                wp_reg <= wp_reg + QPTR_W'(1);
            if (q_pop)
                rp_reg <= rp_reg + QPTR_W'(1);
            if (q_push && !q_pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (q_pop && !q_push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            slot_reg[wp_reg] <= q_wdata;
    end

endmodule

@@ rtl/lbpd_back.sv @@
// ---------------------------------------------------------------------------
// lbpd_back
// Walks the differing neighbours of the head voxel in order and issues one
// pair record per cycle into the result register while it is empty or popped.
// ---------------------------------------------------------------------------
module lbpd_back
    import lbpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  lbpd_entry_t q_head,
    output logic        q_pop,
    input  logic        pop,
    output logic        empty,
    output lbpd_rec_t   rec
);

    logic [NB-1:0] used_reg;
    logic          out_valid_reg;
    lbpd_rec_t     rec_reg;

    logic [NB-1:0]    rem;
    logic [NB-1:0]    sel;
    logic             last;
    logic             load;
    logic [LBL_W-1:0] nl;
    logic [X_W-1:0]   nx;
    logic [Y_W-1:0]   ny;
    logic [Z_W-1:0]   nz;
    lbpd_rec_t        rec_next;

    assign rem  = q_head.mask & ~used_reg;
    assign sel  = rem & (~rem + NB'(1));
    assign last = ((rem & ~sel) == '0);
    assign load = !q_empty && (!out_valid_reg || pop);

    always_comb
    begin
        nl = '0;
        nx = '0;
        ny = '0;
        nz = '0;
        for (int k = 0; k < NB; k++)
        begin
            if (sel[k])
            begin
                nl = nl | q_head.nlab[k];
                nx = nx | (q_head.x + (NB_XM[k] ? {X_W{1'b1}} : X_W'(NB_XP[k])));
                ny = ny | (q_head.y + (NB_YM[k] ? {Y_W{1'b1}} : Y_W'(NB_YP[k])));
                nz = nz | (q_head.z + (NB_ZM[k] ? {Z_W{1'b1}} : '0));
            end
        end
    end

    always_comb
    begin
        rec_next.last_of_run = last;
        if (q_head.label < nl)
        begin
            rec_next.low_label  = q_head.label;
            rec_next.low_x      = q_head.x;
            rec_next.low_y      = q_head.y;
            rec_next.low_z      = q_head.z;
            rec_next.high_label = nl;
            rec_next.high_x     = nx;
            rec_next.high_y     = ny;
            rec_next.high_z     = nz;
        end
        else
        begin
            rec_next.low_label  = nl;
            rec_next.low_x      = nx;
            rec_next.low_y      = ny;
            rec_next.low_z      = nz;
            rec_next.high_label = q_head.label;
            rec_next.high_x     = q_head.x;
            rec_next.high_y     = q_head.y;
            rec_next.high_z     = q_head.z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (last)
                    used_reg <= '0;
                else
                    used_reg <= used_reg | sel;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rec_reg <= rec_next;
    end

    assign q_pop = load && last;
    assign empty = !out_valid_reg;
    assign rec   = rec_reg;

endmodule
